>>> hdl/thrc_pkg.sv
// thrc_pkg: shared types and constants for the triangle half-space region classifier.
// No dependencies.
`default_nettype none
package thrc_pkg;
  localparam int MaxPlanes = 256;
  localparam int CoordBits = 16;
  localparam int IdxW      = $clog2(MaxPlanes);
  localparam int CntW      = IdxW + 1;
  localparam int VecW      = 48;
  localparam int OffW      = 34;
  localparam int TagW      = 16;
  localparam int ProdW     = 2 * CoordBits;
  localparam int DotW      = ProdW + 2;
  localparam int CmpW      = (DotW > OffW) ? DotW : OffW;

  localparam logic [1:0] FUNC_CLEAR    = 2'd0;
  localparam logic [1:0] FUNC_LOAD     = 2'd1;
  localparam logic [1:0] FUNC_CLASSIFY = 2'd2;

  localparam logic [0:0] REG_DEFAULT_REGION = 1'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MAC,
    ST_DONE,
    ST_OUT
  } state_t;

  function automatic logic signed [CoordBits-1:0] comp(input logic [VecW-1:0] v,
                                                        input logic [1:0] k);
    logic signed [CoordBits-1:0] c;
    c = '0;
    case (k)
      2'd0: c = v[CoordBits-1:0];
      2'd1: c = v[2*CoordBits-1:CoordBits];
      2'd2: c = v[3*CoordBits-1:2*CoordBits];
      default: c = '0;
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

>>> hdl/triangle_halfspace_region_classifier.sv
// triangle_halfspace_region_classifier: plane table and sequential classifier.
// Depends on thrc_pkg.
//
// channel | direction | handshake
// in_*    | input     | in_valid / in_stall (driven here)
// out_*   | output    | out_valid / out_stall (driven by sink)
// p*      | APB write | psel, penable, pwrite, pready
//
// From acceptance to the result transaction, clear and load pass through the
// done and output states; a classify visits up to P stored planes, each with a
// table read state plus nine products on one shared multiplier (3 per vertex,
// 3 vertices). The walk stops at the first accepting region. The next item is
// taken in the cycle after the result leaves. Reset (rst_n low, synchronous)
// empties the table and sets default_region to zero. in_stall is high while an
// item is at work or its result waits.
`default_nettype none
module triangle_halfspace_region_classifier
  import thrc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [1:0]        in_func,
  input  wire logic [VecW-1:0]   in_vertex_a,
  input  wire logic [VecW-1:0]   in_vertex_b,
  input  wire logic [VecW-1:0]   in_vertex_c,
  input  wire logic [VecW-1:0]   in_plane_normal,
  input  wire logic signed [OffW-1:0] in_plane_offset,
  input  wire logic [TagW-1:0]   in_region_tag,
  input  wire logic              in_last_of_region,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic              out_status,
  output      logic [TagW-1:0]   out_region_out,
  output      logic              out_matched,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready
);

  logic [VecW-1:0]       normal_mem [MaxPlanes];
  logic [OffW-1:0]       offset_mem [MaxPlanes];
  logic [TagW:0]         tag_mem    [MaxPlanes];

  state_t                state_r, state_nxt;
  logic [CntW-1:0]       count_r;
  logic [TagW-1:0]       default_r;
  logic [CntW-1:0]       idx_r, idx_nxt;
  logic [VecW-1:0]       va_r, vb_r, vc_r;
  logic [VecW-1:0]       nrm_r;
  logic signed [OffW-1:0] off_r;
  logic [TagW:0]         tag_r;
  logic [1:0]            k_r, k_nxt;       // component
  logic [1:0]            v_r, v_nxt;       // vertex
  logic signed [DotW-1:0] acc_r, acc_nxt;
  logic                  allabove_r, allabove_nxt;
  logic                  rej_r, rej_nxt;
  logic                  found_r, found_nxt;
  logic [TagW-1:0]       reg_r, reg_nxt;
  logic                  status_r, status_nxt;
  logic                  ovalid_r;
  logic                  res_load;
  logic                  in_acc, do_load, cfg_wr;
  logic [VecW-1:0]       vsel;
  logic signed [ProdW-1:0] prod;
  logic signed [DotW-1:0] dot;

  assign in_acc  = in_valid && !in_stall;
  assign do_load = in_acc && (in_func == FUNC_LOAD) && (count_r < CntW'(MaxPlanes));
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_DEFAULT_REGION) ? {16'd0, default_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_r <= '0;
    end else if (cfg_wr && paddr[2] == REG_DEFAULT_REGION) begin
      default_r <= pwdata[TagW-1:0];
    end
  end

  // plane table
  always_ff @(posedge clk) begin
    if (do_load) begin
      normal_mem[count_r[IdxW-1:0]] <= in_plane_normal;
      offset_mem[count_r[IdxW-1:0]] <= in_plane_offset;
      tag_mem[count_r[IdxW-1:0]]    <= {in_last_of_region, in_region_tag};
    end
    nrm_r <= normal_mem[idx_r[IdxW-1:0]];
    off_r <= offset_mem[idx_r[IdxW-1:0]];
    tag_r <= tag_mem[idx_r[IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_acc && in_func == FUNC_CLEAR) begin
      count_r <= '0;
    end else if (do_load) begin
      count_r <= count_r + 1'b1;
    end
  end

  // shared multiplier
  always_comb begin
    case (v_r)
      2'd0:    vsel = va_r;
      2'd1:    vsel = vb_r;
      default: vsel = vc_r;
    endcase
  end
  assign prod = comp(nrm_r, k_r) * comp(vsel, k_r);
  assign dot  = acc_r + DotW'(prod);

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    k_nxt        = k_r;
    v_nxt        = v_r;
    acc_nxt      = acc_r;
    allabove_nxt = allabove_r;
    rej_nxt      = rej_r;
    found_nxt    = found_r;
    reg_nxt      = reg_r;
    status_nxt   = status_r;
    res_load     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          idx_nxt    = '0;
          k_nxt      = '0;
          v_nxt      = '0;
          acc_nxt    = '0;
          rej_nxt    = 1'b0;
          found_nxt  = 1'b0;
          reg_nxt    = '0;
          status_nxt = (in_func == FUNC_LOAD) && !do_load;
          if (in_func == FUNC_CLASSIFY) begin
            state_nxt = ST_FETCH;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_FETCH: begin
        // table read registered this cycle
        if (idx_r >= count_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt    = ST_MAC;
          k_nxt        = '0;
          v_nxt        = '0;
          acc_nxt      = '0;
          allabove_nxt = 1'b1;
        end
      end
      ST_MAC: begin
        if (k_r == 2'd2) begin
          k_nxt   = '0;
          acc_nxt = '0;
          if (!(CmpW'(dot) > CmpW'(off_r))) begin
            allabove_nxt = 1'b0;
          end
          if (v_r == 2'd2) begin
            if (CmpW'(dot) > CmpW'(off_r) && allabove_r) begin
              rej_nxt = 1'b1;
            end
            if (tag_r[TagW]) begin
              if (!(rej_r || (CmpW'(dot) > CmpW'(off_r) && allabove_r))) begin
                found_nxt = 1'b1;
                reg_nxt   = tag_r[TagW-1:0];
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_FETCH;
              end
              rej_nxt = 1'b0;
            end else begin
              state_nxt = ST_FETCH;
            end
            idx_nxt = idx_r + 1'b1;
          end else begin
            v_nxt = v_r + 1'b1;
          end
        end else begin
          k_nxt   = k_r + 1'b1;
          acc_nxt = dot;
        end
      end
      ST_DONE: begin
        res_load  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic [1:0] func_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= (state_nxt == ST_OUT);
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    k_r        <= k_nxt;
    v_r        <= v_nxt;
    acc_r      <= acc_nxt;
    allabove_r <= allabove_nxt;
    rej_r      <= rej_nxt;
    found_r    <= found_nxt;
    reg_r      <= reg_nxt;
    status_r   <= status_nxt;
    if (in_acc) begin
      va_r   <= in_vertex_a;
      vb_r   <= in_vertex_b;
      vc_r   <= in_vertex_c;
      func_r <= in_func;
    end
    if (res_load) begin
      out_status  <= status_r;
      out_matched <= found_r;
      if (func_r != FUNC_CLASSIFY) begin
        out_region_out <= '0;
      end else if (found_r) begin
        out_region_out <= reg_r;
      end else begin
        out_region_out <= default_r;
      end
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = ovalid_r;

  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ST_OUT)
    else $error("result valid outside delivery state");
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_region_out))
    else $error("stalled result changed");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(MaxPlanes))
    else $error("plane count beyond capacity");
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_func == FUNC_LOAD && count_r == CntW'(MaxPlanes)) |=> status_r)
    else $error("full-table load not flagged");

endmodule
`default_nettype wire
